/* rtl/tlx_pkg.sv */
package tlx_pkg;

   // Counter width used when the top level is not overridden.
   localparam int COUNT_BITS_DEFAULT = 16;

   // Depth of the token queue in front of the response port.
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   // Token classes.
   localparam logic [4:0] CLS_FILE_END = 5'd0;
   localparam logic [4:0] CLS_LINE_END = 5'd1;
   localparam logic [4:0] CLS_IDENT    = 5'd2;
   localparam logic [4:0] CLS_VALUE    = 5'd3;
   localparam logic [4:0] CLS_DICE     = 5'd4;
   localparam logic [4:0] CLS_COLON    = 5'd5;
   localparam logic [4:0] CLS_COMMA    = 5'd6;
   localparam logic [4:0] CLS_PLUS     = 5'd7;
   localparam logic [4:0] CLS_MINUS    = 5'd8;
   localparam logic [4:0] CLS_TIMES    = 5'd9;
   localparam logic [4:0] CLS_LPAREN   = 5'd10;
   localparam logic [4:0] CLS_RPAREN   = 5'd11;
   localparam logic [4:0] CLS_LBRACE   = 5'd12;
   localparam logic [4:0] CLS_RBRACE   = 5'd13;
   localparam logic [4:0] CLS_LBRACKET = 5'd14;
   localparam logic [4:0] CLS_RBRACKET = 5'd15;
   localparam logic [4:0] CLS_INVALID  = 5'd16;

   // Lexer kinds beyond the token classes.
   localparam logic [4:0] KIND_NONE  = 5'd30;
   localparam logic [4:0] KIND_EMPTY = 5'd31;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LBRACKET   = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET   = 8'h5D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_D    = 8'h64;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;

   typedef struct packed {
      logic [4:0]  token_class;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [15:0] token_length;
      logic [31:0] token_offset;
      logic        final_token;
   } token_type;

   typedef struct packed {
      logic in_comment;
      logic anything_emitted;
      logic last_was_newline;
      logic stream_done;
   } flags_type;

   typedef struct packed {
      logic not_empty;
      logic room_two;
   } queue_status_type;

   function automatic logic [4:0] punct_class(input logic [7:0] c);
      logic [4:0] cls;
      case (c)
         CHAR_COLON:    cls = CLS_COLON;
         CHAR_COMMA:    cls = CLS_COMMA;
         CHAR_PLUS:     cls = CLS_PLUS;
         CHAR_MINUS:    cls = CLS_MINUS;
         CHAR_STAR:     cls = CLS_TIMES;
         CHAR_LPAREN:   cls = CLS_LPAREN;
         CHAR_RPAREN:   cls = CLS_RPAREN;
         CHAR_LBRACE:   cls = CLS_LBRACE;
         CHAR_RBRACE:   cls = CLS_RBRACE;
         CHAR_LBRACKET: cls = CLS_LBRACKET;
         CHAR_RBRACKET: cls = CLS_RBRACKET;
         default:       cls = KIND_NONE;
      endcase
      return cls;
   endfunction

   // Transition of the lexer table; KIND_NONE when the byte cannot follow.
   function automatic logic [4:0] next_kind(input logic [7:0] c, input logic [4:0] kind);
      logic ext_ident;
      logic letter;
      logic digit;
      logic [4:0] nk;
      ext_ident = (kind == CLS_IDENT) || (kind == CLS_DICE);
      letter    = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
                  ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
      digit     = (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
      if (c == CHAR_LF) begin
         nk = ((kind == KIND_EMPTY) || (kind == CLS_LINE_END)) ? CLS_LINE_END : KIND_NONE;
      end else if (letter) begin
         if (kind == KIND_EMPTY) begin
            nk = (c == CHAR_LOWER_D) ? CLS_DICE : CLS_IDENT;
         end else begin
            nk = ext_ident ? CLS_IDENT : KIND_NONE;
         end
      end else if (digit) begin
         if ((kind == KIND_EMPTY) || (kind == CLS_VALUE)) begin
            nk = CLS_VALUE;
         end else begin
            nk = (kind == CLS_IDENT) ? CLS_IDENT : KIND_NONE;
         end
      end else if (c == CHAR_UNDERSCORE) begin
         nk = ext_ident ? CLS_IDENT : KIND_NONE;
      end else begin
         nk = (kind == KIND_EMPTY) ? punct_class(c) : KIND_NONE;
      end
      return nk;
   endfunction

endpackage

/* rtl/table_driven_token_lexer_core.sv */
// Streaming lexer that takes one text byte per request and returns tokens
// found by longest match: identifiers, decimal values, the lone 'd' dice
// operator, single-byte punctuation, runs of line feeds, and a file-end
// token for the NUL byte. Spaces, tabs and '#' comments are skipped, and
// each token carries its starting line, column and byte offset. A token is
// returned when the byte that cannot extend it arrives, so one request
// yields zero, one or two tokens; a NUL or an unknown start byte yields a
// final token, after which requests are still taken but ignored until
// reset. The block takes a request every cycle while req_stall is low:
// each byte is latched in an input register and handled in the following
// cycle, unless the queue lacks room, by a single pass of table decode and
// saturating counter updates, and the tokens go into a four-entry queue
// whose head drives the response port, so a token reaches rsp_valid through
// the input register and the queue. The request side stalls only while that
// queue holds more than two tokens, which happens when the response side
// stalls; the response port hands out one token per cycle unless stalled.
module table_driven_token_lexer_core #(
   parameter int COUNT_BITS = tlx_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_class,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [15:0] rsp_token_length,
   output logic [31:0] rsp_token_offset,
   output logic        rsp_final_token
);
   import tlx_pkg::*;

   // Input register.
   logic       req_valid_ff;
   logic       req_valid_in;
   logic [7:0] req_byte_ff;

   // Lexer state.
   logic [4:0]            kind_ff;
   logic [4:0]            kind_in;
   logic [COUNT_BITS-1:0] run_length_ff;
   logic [COUNT_BITS-1:0] run_length_in;
   logic [COUNT_BITS-1:0] start_line_ff;
   logic [COUNT_BITS-1:0] start_line_in;
   logic [COUNT_BITS-1:0] start_column_ff;
   logic [COUNT_BITS-1:0] start_column_in;
   logic [31:0]           start_offset_ff;
   logic [31:0]           start_offset_in;
   logic [COUNT_BITS-1:0] cur_line_ff;
   logic [COUNT_BITS-1:0] cur_line_in;
   logic [COUNT_BITS-1:0] cur_column_ff;
   logic [COUNT_BITS-1:0] cur_column_in;
   logic [31:0]           byte_offset_ff;
   logic [31:0]           byte_offset_in;
   flags_type             flags_ff;
   flags_type             flags_in;

   logic             fire;
   logic [1:0]       res_count;
   logic [1:0]       push_count;
   token_type        tok0;
   token_type        tok1;
   token_type        head_tok;
   queue_status_type q_status;

   // The latched byte is processed once the queue can take two tokens,
   // which is the most that one byte can produce.
   assign fire         = req_valid_ff && q_status.room_two;
   assign req_stall    = req_valid_ff && !q_status.room_two;
   assign req_valid_in = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_byte_ff <= req_text_byte;
      end
   end

   tlx_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .text_byte      (req_byte_ff),
      .kind           (kind_ff),
      .run_length     (run_length_ff),
      .start_line     (start_line_ff),
      .start_column   (start_column_ff),
      .start_offset   (start_offset_ff),
      .cur_line       (cur_line_ff),
      .cur_column     (cur_column_ff),
      .byte_offset    (byte_offset_ff),
      .flags          (flags_ff),
      .kind_n         (kind_in),
      .run_length_n   (run_length_in),
      .start_line_n   (start_line_in),
      .start_column_n (start_column_in),
      .start_offset_n (start_offset_in),
      .cur_line_n     (cur_line_in),
      .cur_column_n   (cur_column_in),
      .byte_offset_n  (byte_offset_in),
      .flags_n        (flags_in),
      .res_count      (res_count),
      .tok0           (tok0),
      .tok1           (tok1)
   );

   // The lexer state advances only when a latched byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff         <= KIND_EMPTY;
         run_length_ff   <= '0;
         start_line_ff   <= COUNT_BITS'(1);
         start_column_ff <= COUNT_BITS'(1);
         start_offset_ff <= '0;
         cur_line_ff     <= COUNT_BITS'(1);
         cur_column_ff   <= COUNT_BITS'(1);
         byte_offset_ff  <= '0;
         flags_ff        <= '0;
      end else if (fire) begin
         kind_ff         <= kind_in;
         run_length_ff   <= run_length_in;
         start_line_ff   <= start_line_in;
         start_column_ff <= start_column_in;
         start_offset_ff <= start_offset_in;
         cur_line_ff     <= cur_line_in;
         cur_column_ff   <= cur_column_in;
         byte_offset_ff  <= byte_offset_in;
         flags_ff        <= flags_in;
      end
   end

   assign push_count = fire ? res_count : 2'd0;

   tlx_token_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_tok0  (tok0),
      .push_tok1  (tok1),
      .pop        (rsp_valid && !rsp_stall),
      .head_tok   (head_tok),
      .status     (q_status)
   );

   assign rsp_valid        = q_status.not_empty;
   assign rsp_token_class  = head_tok.token_class;
   assign rsp_token_line   = head_tok.token_line;
   assign rsp_token_column = head_tok.token_column;
   assign rsp_token_length = head_tok.token_length;
   assign rsp_token_offset = head_tok.token_offset;
   assign rsp_final_token  = head_tok.final_token;

   // Once the final token has been queued, no byte may produce another token.
   a_silent_after_final: assert property (@(posedge clock) disable iff (reset)
      flags_ff.stream_done |-> (push_count == 2'd0))
      else $error("token produced after the final token");

   // Two tokens from one byte are always a closed token followed by a
   // final token.
   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (push_count == 2'd2) |-> (tok1.final_token && !tok0.final_token))
      else $error("unexpected pair of tokens from one byte");

   // The stream ends only on a byte that pushed a final token.
   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(flags_ff.stream_done) |->
         ($past(push_count) != 2'd0) &&
         (($past(push_count) == 2'd2) ? $past(tok1.final_token)
                                      : $past(tok0.final_token)))
      else $error("stream ended without a final token");

endmodule

/* rtl/tlx_step.sv */
module tlx_step #(
   parameter int COUNT_BITS = tlx_pkg::COUNT_BITS_DEFAULT
) (
   input  logic [7:0]               text_byte,
   input  logic [4:0]               kind,
   input  logic [COUNT_BITS-1:0]    run_length,
   input  logic [COUNT_BITS-1:0]    start_line,
   input  logic [COUNT_BITS-1:0]    start_column,
   input  logic [31:0]              start_offset,
   input  logic [COUNT_BITS-1:0]    cur_line,
   input  logic [COUNT_BITS-1:0]    cur_column,
   input  logic [31:0]              byte_offset,
   input  tlx_pkg::flags_type       flags,
   output logic [4:0]               kind_n,
   output logic [COUNT_BITS-1:0]    run_length_n,
   output logic [COUNT_BITS-1:0]    start_line_n,
   output logic [COUNT_BITS-1:0]    start_column_n,
   output logic [31:0]              start_offset_n,
   output logic [COUNT_BITS-1:0]    cur_line_n,
   output logic [COUNT_BITS-1:0]    cur_column_n,
   output logic [31:0]              byte_offset_n,
   output tlx_pkg::flags_type       flags_n,
   output logic [1:0]               res_count,
   output tlx_pkg::token_type       tok0,
   output tlx_pkg::token_type       tok1
);
   import tlx_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic       skip;
   logic [4:0] nk_open;
   logic [4:0] nk_start;
   token_type  tok_second;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
      return (a == COUNT_MAX) ? a : a + COUNT_BITS'(1);
   endfunction

   function automatic logic [31:0] off_inc(input logic [31:0] a);
      return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
   endfunction

   assign nk_open  = next_kind(text_byte, kind);
   assign nk_start = next_kind(text_byte, KIND_EMPTY);

   always_comb begin
      kind_n         = kind;
      run_length_n   = run_length;
      start_line_n   = start_line;
      start_column_n = start_column;
      start_offset_n = start_offset;
      cur_line_n     = cur_line;
      cur_column_n   = cur_column;
      byte_offset_n  = byte_offset;
      flags_n        = flags;
      res_count      = 2'd0;
      tok0           = '0;
      tok1           = '0;
      tok_second     = '0;
      skip           = flags.stream_done;

      // Comment bytes only move the byte offset; line feed or NUL ends it.
      if (!skip && flags.in_comment) begin
         if ((text_byte != CHAR_LF) && (text_byte != CHAR_NUL)) begin
            byte_offset_n = off_inc(byte_offset);
            skip          = 1'b1;
         end else begin
            flags_n.in_comment = 1'b0;
         end
      end

      // Extend the open token, or close it.
      if (!skip && (kind != KIND_EMPTY)) begin
         if (nk_open != KIND_NONE) begin
            kind_n        = nk_open;
            run_length_n  = sat_inc(run_length);
            byte_offset_n = off_inc(byte_offset);
            skip          = 1'b1;
         end else begin
            if (kind == CLS_LINE_END) begin
               if (flags.anything_emitted && !flags.last_was_newline) begin
                  tok0 = '{CLS_LINE_END, 16'(start_line), 16'(start_column),
                           16'(run_length), start_offset, 1'b0};
                  res_count                = 2'd1;
                  flags_n.anything_emitted = 1'b1;
                  flags_n.last_was_newline = 1'b1;
               end
               cur_line_n   = sat_add(cur_line, run_length);
               cur_column_n = COUNT_BITS'(1);
            end else begin
               tok0 = '{kind, 16'(start_line), 16'(start_column),
                        16'(run_length), start_offset, 1'b0};
               res_count                = 2'd1;
               flags_n.anything_emitted = 1'b1;
               flags_n.last_was_newline = 1'b0;
               cur_column_n             = sat_add(cur_column, run_length);
            end
            kind_n       = KIND_EMPTY;
            run_length_n = '0;
         end
      end

      // The byte itself, seen with nothing open.
      if (!skip) begin
         if ((text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB)) begin
            cur_column_n  = sat_inc(cur_column_n);
            byte_offset_n = off_inc(byte_offset);
         end else if (text_byte == CHAR_HASH) begin
            flags_n.in_comment = 1'b1;
            byte_offset_n      = off_inc(byte_offset);
         end else if ((text_byte == CHAR_NUL) || (nk_start == KIND_NONE)) begin
            if (text_byte == CHAR_NUL) begin
               tok_second = '{CLS_FILE_END, 16'(cur_line_n), 16'(cur_column_n),
                              16'd1, byte_offset, 1'b1};
            end else begin
               tok_second = '{CLS_INVALID, 16'(cur_line_n), 16'(cur_column_n),
                              16'd0, byte_offset, 1'b1};
            end
            if (res_count == 2'd0) begin
               tok0 = tok_second;
            end else begin
               tok1 = tok_second;
            end
            res_count           = res_count + 2'd1;
            flags_n.stream_done = 1'b1;
         end else begin
            kind_n         = nk_start;
            run_length_n   = COUNT_BITS'(1);
            start_line_n   = cur_line_n;
            start_column_n = cur_column_n;
            start_offset_n = byte_offset;
            byte_offset_n  = off_inc(byte_offset);
         end
      end
   end

endmodule

/* rtl/tlx_token_queue.sv */
module tlx_token_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  tlx_pkg::token_type        push_tok0,
   input  tlx_pkg::token_type        push_tok1,
   input  logic                      pop,
   output tlx_pkg::token_type        head_tok,
   output tlx_pkg::queue_status_type status
);
   import tlx_pkg::*;

   token_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff;
   logic [Q_PTR_BITS-1:0] wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff;
   logic [Q_PTR_BITS-1:0] rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff;
   logic [Q_CNT_BITS-1:0] count_in;

   assign wr_ptr_in = wr_ptr_ff + Q_PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + Q_PTR_BITS'(pop);
   assign count_in  = count_ff + Q_CNT_BITS'(push_count) - Q_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_tok0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + Q_PTR_BITS'(1)] <= push_tok1;
      end
   end

   assign head_tok         = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room_two  = (count_ff <= Q_CNT_BITS'(Q_DEPTH - 2));

endmodule

/* tb/sv/tb_table_driven_token_lexer_core.sv */
`timescale 1ns / 100ps

module tb_table_driven_token_lexer_core;
   import tlx_pkg::*;

   // The run is one long text stream, because the lexer only starts over on
   // reset and reset is applied once. The generous limit covers the whole
   // stream plus all of the random idling and the long response hold-off.
   localparam int CYCLE_LIMIT = 100_000;
   localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_BITS_DEFAULT) - 32'd1;
   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;
   localparam int LONG_RUN = 30;

   typedef enum int {
      END_IN_WORD,
      END_IN_VALUE_BAD_BYTE,
      END_IN_COMMENT,
      END_IN_LINE_FEEDS
   } ending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_class;
   logic [15:0] rsp_token_line;
   logic [15:0] rsp_token_column;
   logic [15:0] rsp_token_length;
   logic [31:0] rsp_token_offset;
   logic        rsp_final_token;

   table_driven_token_lexer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_class  (rsp_token_class),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_token_length (rsp_token_length),
      .rsp_token_offset (rsp_token_offset),
      .rsp_final_token  (rsp_final_token)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Text bytes waiting to be sent, and tokens that the lexer still owes us.
   logic [7:0] text_queue[$];
   token_type  expected_tokens[$];
   int         stimulus_bytes = 0;
   int         mismatch_count = 0;

   // Idle percentages of both sides, and a long response hold-off that the
   // stimulus block arms and the response process counts down.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   // Our own copy of the lexer state.
   logic [4:0]  lx_kind;
   logic [31:0] lx_run;
   logic [31:0] lx_start_line;
   logic [31:0] lx_start_col;
   logic [31:0] lx_start_off;
   logic [31:0] lx_line;
   logic [31:0] lx_col;
   logic [31:0] lx_off;
   logic        lx_in_comment;
   logic        lx_emitted;
   logic        lx_last_newline;
   logic        lx_done;

   function automatic logic [31:0] sat_count(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[31:0];
   endfunction

   function automatic logic [31:0] sat_offset(input logic [31:0] a);
      logic [32:0] sum;
      sum = {1'b0, a} + 33'd1;
      return sum[32] ? OFFSET_MAX : sum[31:0];
   endfunction

   // Kind of token that results when byte c arrives while kind is open, or
   // KIND_NONE when c cannot continue it (or, from empty, cannot start one).
   function automatic logic [4:0] follow_kind(input logic [7:0] c, input logic [4:0] kind);
      logic is_alpha;
      logic is_num;
      logic wordish;
      is_alpha = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
                 (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
      is_num   = (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9);
      wordish  = (kind == CLS_IDENT) || (kind == CLS_DICE);
      if (kind == KIND_EMPTY) begin
         if (c == CHAR_LF) return CLS_LINE_END;
         if (is_alpha) return (c == CHAR_LOWER_D) ? CLS_DICE : CLS_IDENT;
         if (is_num) return CLS_VALUE;
         case (c)
            CHAR_COLON:    return CLS_COLON;
            CHAR_COMMA:    return CLS_COMMA;
            CHAR_PLUS:     return CLS_PLUS;
            CHAR_MINUS:    return CLS_MINUS;
            CHAR_STAR:     return CLS_TIMES;
            CHAR_LPAREN:   return CLS_LPAREN;
            CHAR_RPAREN:   return CLS_RPAREN;
            CHAR_LBRACE:   return CLS_LBRACE;
            CHAR_RBRACE:   return CLS_RBRACE;
            CHAR_LBRACKET: return CLS_LBRACKET;
            CHAR_RBRACKET: return CLS_RBRACKET;
            default:       return KIND_NONE;
         endcase
      end
      if (c == CHAR_LF) return (kind == CLS_LINE_END) ? CLS_LINE_END : KIND_NONE;
      if (is_alpha || c == CHAR_UNDERSCORE) return wordish ? CLS_IDENT : KIND_NONE;
      // A digit extends a value or an identifier, but not a lone 'd'.
      if (is_num) return (kind == CLS_VALUE || kind == CLS_IDENT) ? kind : KIND_NONE;
      return KIND_NONE;
   endfunction

   task automatic lexer_clear();
      lx_kind         = KIND_EMPTY;
      lx_run          = 32'd0;
      lx_start_line   = 32'd1;
      lx_start_col    = 32'd1;
      lx_start_off    = 32'd0;
      lx_line         = 32'd1;
      lx_col          = 32'd1;
      lx_off          = 32'd0;
      lx_in_comment   = 1'b0;
      lx_emitted      = 1'b0;
      lx_last_newline = 1'b0;
      lx_done         = 1'b0;
   endtask

   task automatic owe_token(input logic [4:0] cls, input logic [31:0] line,
                            input logic [31:0] col, input logic [31:0] len,
                            input logic [31:0] off, input logic fin);
      token_type t;
      t.token_class  = cls;
      t.token_line   = line[15:0];
      t.token_column = col[15:0];
      t.token_length = len[15:0];
      t.token_offset = off;
      t.final_token  = fin;
      expected_tokens.push_back(t);
   endtask

   // Advances our lexer copy by one accepted byte and records the tokens
   // that byte closes.
   task automatic lex_byte(input logic [7:0] c);
      logic [4:0] nk;
      if (lx_done) return;
      if (lx_in_comment) begin
         if (c != CHAR_LF && c != CHAR_NUL) begin
            lx_off = sat_offset(lx_off);
            return;
         end
         lx_in_comment = 1'b0;
      end
      if (lx_kind != KIND_EMPTY) begin
         nk = follow_kind(c, lx_kind);
         if (nk != KIND_NONE) begin
            lx_kind = nk;
            lx_run  = sat_count(lx_run, 32'd1);
            lx_off  = sat_offset(lx_off);
            return;
         end
         if (lx_kind == CLS_LINE_END) begin
            // Line ends that would lead the stream or follow another line
            // end are swallowed, but the line count moves on regardless.
            if (lx_emitted && !lx_last_newline) begin
               owe_token(CLS_LINE_END, lx_start_line, lx_start_col, lx_run,
                         lx_start_off, 1'b0);
               lx_last_newline = 1'b1;
            end
            lx_line = sat_count(lx_line, lx_run);
            lx_col  = 32'd1;
         end else begin
            owe_token(lx_kind, lx_start_line, lx_start_col, lx_run, lx_start_off, 1'b0);
            lx_emitted      = 1'b1;
            lx_last_newline = 1'b0;
            lx_col          = sat_count(lx_col, lx_run);
         end
         lx_kind = KIND_EMPTY;
         lx_run  = 32'd0;
      end
      if (c == CHAR_SPACE || c == CHAR_TAB) begin
         lx_col = sat_count(lx_col, 32'd1);
         lx_off = sat_offset(lx_off);
         return;
      end
      if (c == CHAR_HASH) begin
         lx_in_comment = 1'b1;
         lx_off        = sat_offset(lx_off);
         return;
      end
      if (c == CHAR_NUL) begin
         owe_token(CLS_FILE_END, lx_line, lx_col, 32'd1, lx_off, 1'b1);
         lx_done = 1'b1;
         return;
      end
      nk = follow_kind(c, KIND_EMPTY);
      if (nk == KIND_NONE) begin
         owe_token(CLS_INVALID, lx_line, lx_col, 32'd0, lx_off, 1'b1);
         lx_done = 1'b1;
         return;
      end
      lx_kind       = nk;
      lx_run        = 32'd1;
      lx_start_line = lx_line;
      lx_start_col  = lx_col;
      lx_start_off  = lx_off;
      lx_off        = sat_offset(lx_off);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: token mismatch on %s: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want);
   endtask

   // Request driver: presents the next queued byte, holds it while stalled,
   // and feeds every accepted byte to the lexer copy.
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_text_byte <= 8'd0;
      end else begin
         if (req_valid && !req_stall) begin
            lex_byte(req_text_byte);
         end
         if (!req_valid || !req_stall) begin
            if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_text_byte <= text_queue.pop_front();
            end else begin
               req_valid     <= 1'b0;
               req_text_byte <= 8'($urandom);
            end
         end
      end
   end

   // Response monitor: checks each accepted token against the oldest one
   // owed, and drives the response stall, either at random or for a long
   // hold-off when one is armed.
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected token class", 32'(rsp_token_class), 32'd0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_class != want.token_class)
                  report_mismatch("class", 32'(rsp_token_class), 32'(want.token_class));
               if (rsp_token_line != want.token_line)
                  report_mismatch("line", 32'(rsp_token_line), 32'(want.token_line));
               if (rsp_token_column != want.token_column)
                  report_mismatch("column", 32'(rsp_token_column), 32'(want.token_column));
               if (rsp_token_length != want.token_length)
                  report_mismatch("length", 32'(rsp_token_length), 32'(want.token_length));
               if (rsp_token_offset != want.token_offset)
                  report_mismatch("offset", rsp_token_offset, want.token_offset);
               if (rsp_final_token != want.final_token)
                  report_mismatch("final flag", 32'(rsp_final_token), 32'(want.final_token));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic add_byte(input logic [7:0] c);
      text_queue.push_back(c);
      stimulus_bytes++;
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1))
         return CHAR_LOWER_A + 8'($urandom_range(25));
      return CHAR_UPPER_A + 8'($urandom_range(25));
   endfunction

   // Any byte that may follow the first letter of an identifier.
   function automatic logic [7:0] rand_word_byte();
      case ($urandom_range(5))
         0:       return CHAR_UNDERSCORE;
         1, 2:    return CHAR_DIGIT_0 + 8'($urandom_range(9));
         default: return rand_letter();
      endcase
   endfunction

   function automatic logic [7:0] rand_punct();
      logic [7:0] marks[11];
      marks = '{CHAR_COLON, CHAR_COMMA, CHAR_PLUS, CHAR_MINUS, CHAR_STAR,
                CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACE, CHAR_RBRACE,
                CHAR_LBRACKET, CHAR_RBRACKET};
      return marks[$urandom_range(10)];
   endfunction

   // Comment bodies carry arbitrary bytes, which is the only place where the
   // upper half of the byte range can appear without ending the stream.
   function automatic logic [7:0] rand_comment_byte();
      logic [7:0] c;
      c = 8'($urandom_range(255, 1));
      return (c == CHAR_LF) ? c + 8'd1 : c;
   endfunction

   // A byte that can start no token and is not skipped either.
   function automatic logic [7:0] rand_bad_start();
      logic [7:0] c;
      c = 8'($urandom_range(255, 1));
      while (follow_kind(c, KIND_EMPTY) != KIND_NONE || c == CHAR_SPACE ||
             c == CHAR_TAB || c == CHAR_HASH) begin
         c = 8'($urandom_range(255, 1));
      end
      return c;
   endfunction

   // Appends one lexical piece. Most of the time a blank follows; when it
   // does not, neighbors run into each other, which exercises the longest
   // match rules (a value followed by a word, a 'd' followed by a digit).
   task automatic add_piece();
      int n;
      case ($urandom_range(9))
         0, 1: begin
            add_byte(rand_letter());
            n = $urandom_range(7);
            repeat (n) add_byte(rand_word_byte());
         end
         2: begin
            add_byte(CHAR_LOWER_D);
         end
         3, 4: begin
            n = $urandom_range(5, 1);
            repeat (n) add_byte(CHAR_DIGIT_0 + 8'($urandom_range(9)));
         end
         5, 6: begin
            add_byte(rand_punct());
         end
         7: begin
            n = $urandom_range(3, 1);
            repeat (n) add_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
         end
         8: begin
            n = $urandom_range(3, 1);
            repeat (n) add_byte(CHAR_LF);
         end
         default: begin
            add_byte(CHAR_HASH);
            n = $urandom_range(6);
            repeat (n) add_byte(rand_comment_byte());
            if ($urandom_range(3) != 0) add_byte(CHAR_LF);
         end
      endcase
      if ($urandom_range(9) < 6) add_byte($urandom_range(3) != 0 ? CHAR_SPACE : CHAR_TAB);
   endtask

   task automatic add_random(input int count);
      int target;
      target = stimulus_bytes + count;
      while (stimulus_bytes < target) add_piece();
   endtask

   task automatic wait_sent();
      while (text_queue.size() != 0 || req_valid) @(negedge clock);
   endtask

   task automatic wait_quiet();
      while (text_queue.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(negedge clock);
   endtask

   // Watchdog: a stuck handshake or a token that never shows up ends here.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("table_driven_token_lexer_core test failed");
      $finish;
   end

   initial begin : stimulus
      ending_type ending;
      int n;
      lexer_clear();
      send_idle_pct = 21;
      recv_idle_pct = 57;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: a leading line feed that must be swallowed, a lone
      // dice operator, an identifier with the letter and digit extremes and
      // an underscore, a value closed directly by a colon that the other
      // punctuation marks follow, a line end, and a comment with a high byte
      // whose closing line feed would repeat the line end and so is swallowed too.
      add_byte(CHAR_LF);
      add_string("d aZz_09A\t90:,+-*(){}[]\n#");
      add_byte(8'hFF);
      add_byte(CHAR_LF);
      add_random(340);

      // The sender pauses until every owed token has come back, then the
      // idle rates of the two sides swap.
      wait_quiet();
      send_idle_pct = 57;
      recv_idle_pct = 21;
      add_random(340);
      wait_sent();

      // No idling from here on. The response side first holds off for a
      // long stretch while bytes keep coming, so the token queue fills and
      // the request side has to stall.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(350);
      hold_left = 400;

      // A long identifier, then a long run of line feeds.
      add_byte(CHAR_UPPER_Z);
      repeat (LONG_RUN) add_byte(rand_word_byte());
      add_byte(CHAR_SPACE);
      repeat (LONG_RUN) add_byte(CHAR_LF);
      add_string("7+x ");

      // The stream can end only once per reset, so the seed picks how: with
      // an open token closed by the end of text, with a byte that starts no
      // token, from inside a comment, or inside a run of line feeds.
      ending = ending_type'($urandom_range(3));
      case (ending)
         END_IN_WORD: begin
            add_string("k_9");
            add_byte(CHAR_NUL);
         end
         END_IN_VALUE_BAD_BYTE: begin
            add_string("42");
            add_byte(rand_bad_start());
         end
         END_IN_COMMENT: begin
            add_byte(CHAR_HASH);
            add_byte(rand_comment_byte());
            add_byte(CHAR_NUL);
         end
         default: begin
            add_string("Q\n\n");
            add_byte(CHAR_NUL);
         end
      endcase

      // Everything after the final token is ignored, whatever the byte.
      n = 20;
      repeat (n) add_byte(8'($urandom));

      wait_quiet();
      // Give a stray late token the chance to show up as unexpected.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("table_driven_token_lexer_core test passed");
      end else begin
         $display("table_driven_token_lexer_core test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/tlx_pkg.sv
rtl/tlx_step.sv
rtl/tlx_token_queue.sv
rtl/table_driven_token_lexer_core.sv
tb/sv/tb_table_driven_token_lexer_core.sv
